// ===== rtl/core/fnvh_pkg.sv =====
// ----------------------------------------------------------------------------
// fnvh_pkg
// shared types and constants of the fnv-1a 64-bit word hasher
// ----------------------------------------------------------------------------
package fnvh_pkg;

    localparam int FNVH_WORD_W  = 64;
    localparam int FNVH_CNT_W   = 4;
    localparam int FNVH_BYTE_W  = 8;

    // offset basis and the low part of the prime (prime = 2^40 + 0x1b3)
    localparam logic [FNVH_WORD_W-1:0] FNVH_BASIS    = 64'hCBF2_9CE4_8422_2325;
    localparam logic [8:0]             FNVH_PRIME_LO = 9'h1B3;
    localparam int                     FNVH_PRIME_SH = 40;

    localparam logic [FNVH_CNT_W-1:0] FNVH_MAX_BYTES   = 4'd8;
    localparam logic [FNVH_CNT_W-1:0] FNVH_DEPTH_BYTES = 4'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_EMIT
    } t_fnvh_state;

    // one xor-multiply round: (h ^ b) * prime mod 2^64
    function automatic logic [FNVH_WORD_W-1:0] fnvh_round(
        input logic [FNVH_WORD_W-1:0] h,
        input logic [FNVH_BYTE_W-1:0] b
    );
        logic [FNVH_WORD_W-1:0] x;
        logic [FNVH_WORD_W-1:0] lo;
        x  = h ^ {{(FNVH_WORD_W-FNVH_BYTE_W){1'b0}}, b};
        lo = x * {{(FNVH_WORD_W-9){1'b0}}, FNVH_PRIME_LO};
        return lo + (x << FNVH_PRIME_SH);
    endfunction

    // single-float depth bits -> two's complement of round(d*1024), clamped
    function automatic logic [31:0] fnvh_quantize(input logic [31:0] fbits);
        logic        sign;
        logic [7:0]  expo;
        logic [23:0] sig;
        logic [32:0] mag;
        logic [32:0] x;
        logic [3:0]  lsh;
        logic [4:0]  rsh;
        logic [31:0] res;
        sign = fbits[31];
        expo = fbits[30:23];
        sig  = {1'b1, fbits[22:0]};
        lsh  = 4'(expo - 8'd140);
        rsh  = 5'(8'd139 - expo);
        x    = {9'b0, sig} >> rsh;
        if (expo > 8'd148) begin
            mag = 33'h1_0000_0000;
        end else if (expo >= 8'd140) begin
            mag = {9'b0, sig} << lsh;
        end else if (expo >= 8'd116) begin
            mag = (x >> 1) + {32'b0, x[0]};
        end else begin
            mag = '0;
        end
        if (expo == 8'hFF || expo == 8'h00) begin
            res = '0;
        end else if (sign) begin
            if (mag > 33'h0_8000_0000) begin
                mag = 33'h0_8000_0000;
            end
            res = 32'(33'd0 - mag);
        end else begin
            if (mag > 33'h0_7FFF_FFFF) begin
                mag = 33'h0_7FFF_FFFF;
            end
            res = mag[31:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/fnvh_if.sv =====
// ----------------------------------------------------------------------------
// fnvh_in_if / fnvh_out_if
// valid/ready channels carrying input words and finished hashes
// ----------------------------------------------------------------------------
interface fnvh_in_if;
    import fnvh_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FNVH_WORD_W-1:0] value;
    logic [FNVH_CNT_W-1:0]  byte_count;
    logic                   quantize_depth;
    logic                   first;
    logic                   last;

    modport source (
        output valid, value, byte_count, quantize_depth, first, last,
        input  ready
    );
    modport sink (
        input  valid, value, byte_count, quantize_depth, first, last,
        output ready
    );
endinterface

interface fnvh_out_if;
    import fnvh_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FNVH_WORD_W-1:0] hash;

    modport source (output valid, hash, input ready);
    modport sink (input valid, hash, output ready);
endinterface

// ===== rtl/core/fnv1a64_word_hasher_top.sv =====
// ----------------------------------------------------------------------------
// fnv1a64_word_hasher_top
// running 64-bit fnv-1a hash over the low bytes of integer words
// ----------------------------------------------------------------------------
// Each input beat absorbs 1 to 8 low bytes of its value, least significant
// first (a count above 8 absorbs 8, a count of 0 absorbs nothing). With
// quantize_depth set, the low 32 bits are read as a single-float depth,
// turned into round(depth*1024) clamped to int32 (non-finite gives 0) and
// absorbed as 4 bytes. first reloads the offset basis before absorbing; last
// sends the hash out as one output beat after absorbing. A single xor and
// constant multiply-add unit processes one byte per cycle, so an input beat
// holds the block while its bytes are absorbed (4 when quantizing) and,
// when last is set, through the emit state, which waits while the output
// register stays full. The input ready is high only between items. The
// result is held in an output register until it is taken.
// ----------------------------------------------------------------------------
module fnv1a64_word_hasher_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    fnvh_in_if.sink         i_in,
    fnvh_out_if.source      o_out
);
    import fnvh_pkg::*;

    t_fnvh_state             r_state;
    t_fnvh_state             n_state;
    logic [FNVH_WORD_W-1:0]  r_hash;       // running hash
    logic [FNVH_WORD_W-1:0]  r_word;       // bytes still to absorb, lsb first
    logic [FNVH_CNT_W-1:0]   r_cnt;        // bytes left
    logic                    r_last;
    logic                    r_out_valid;
    logic [FNVH_WORD_W-1:0]  r_out_hash;

    logic                    w_accept;
    logic                    w_out_free;
    logic                    w_load_out;
    logic [FNVH_CNT_W-1:0]   w_in_cnt;
    logic [FNVH_WORD_W-1:0]  w_in_word;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    // byte count and word as seen by the absorb loop
    always_comb begin
        if (i_in.quantize_depth) begin
            w_in_cnt  = FNVH_DEPTH_BYTES;
            w_in_word = {32'b0, fnvh_quantize(i_in.value[31:0])};
        end else begin
            w_in_cnt  = (i_in.byte_count > FNVH_MAX_BYTES) ? FNVH_MAX_BYTES
                                                           : i_in.byte_count;
            w_in_word = i_in.value;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_in_cnt != '0) begin
                        n_state = ST_ABSORB;
                    end else if (i_in.last) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_ABSORB: begin
                // final byte goes in this cycle
                if (r_cnt == FNVH_CNT_W'(1)) begin
                    n_state = r_last ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_in.ready = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            ST_IDLE:   i_in.ready = 1'b1;
            ST_ABSORB: ;
            ST_EMIT:   w_load_out = w_out_free;
            default:   ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hash      <= FNVH_BASIS;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;

            // input beat: optional basis reload, capture the bytes
            if (w_accept) begin
                if (i_in.first) begin
                    r_hash <= FNVH_BASIS;
                end
                r_cnt <= w_in_cnt;
            end else if (r_state == ST_ABSORB) begin
                // one byte through the shared round unit per cycle
                r_hash <= fnvh_round(r_hash, r_word[FNVH_BYTE_W-1:0]);
                r_cnt  <= r_cnt - FNVH_CNT_W'(1);
            end

            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word <= w_in_word;
            r_last <= i_in.last;
        end else if (r_state == ST_ABSORB) begin
            r_word <= r_word >> FNVH_BYTE_W;
        end
        if (w_load_out) begin
            r_out_hash <= r_hash;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.hash  = r_out_hash;

    // first reloads the basis on the beat itself
    a_first_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.first) |=> (r_hash == FNVH_BASIS))
        else $error("basis not loaded after first beat");

    // byte counter never passes eight
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= FNVH_MAX_BYTES))
        else $error("byte counter out of range");

    // absorbing always has a byte left
    a_absorb_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ABSORB) |-> (r_cnt != '0))
        else $error("absorb state with no bytes left");

    // quantized depth always takes four rounds
    a_quant_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.quantize_depth) |=> (r_cnt == FNVH_DEPTH_BYTES))
        else $error("quantized depth not four bytes");

    // a result appears only out of the emit state
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_EMIT))
        else $error("output loaded outside emit");

endmodule
